[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is low
`define VZC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check with a fixed message
`define VZC_ASSERT_PORT(label, clk, rst_n, prop) \
    `VZC_ASSERT(label, clk, rst_n, prop, "vzc port check failed")

`endif

[hw/rtl/vzc_pkg.sv]
// shared types and constants of the varint / zigzag codec
// used by the controller, the datapath and the top level
package vzc_pkg;

    localparam int GROUP_BITS   = 7;
    localparam int NARROW_BYTES = 5;
    localparam int WIDE_BYTES   = 10;
    localparam int ENC_MAX_CNT  = 9;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    typedef struct packed {
        logic load_enc;   // accept an encode beat, emit its first byte
        logic step_enc;   // emit the next byte of the running encode
        logic dec_byte;   // accept a decode byte
    } t_dp_cmd;

    typedef struct packed {
        logic enc_more;   // encode byte being emitted is not the last
        logic dec_done;   // decode byte closes the varint
    } t_dp_status;

endpackage

[hw/rtl/vzc_ctrl.sv]
// controller state machine of the codec: handshakes and output valid
// depends on vzc_pkg
module vzc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_operation,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  vzc_pkg::t_dp_status i_status,
    output vzc_pkg::t_dp_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ENC  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic accept;
    logic emit;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load_enc = accept && (i_operation == vzc_pkg::OP_ENCODE);
        o_cmd.dec_byte = accept && (i_operation == vzc_pkg::OP_DECODE);
        o_cmd.step_enc = (r_state == ST_ENC) && out_free;
    end

    assign emit = o_cmd.load_enc || o_cmd.step_enc || (o_cmd.dec_byte && i_status.dec_done);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load_enc && i_status.enc_more) n_state = ST_ENC;
            end
            ST_ENC: begin
                if (o_cmd.step_enc && !i_status.enc_more) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/vzc_datapath.sv]
// datapath of the codec: zigzag map, encode shifter, decode accumulator
// and the output register; depends on vzc_pkg
module vzc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vzc_pkg::t_dp_cmd    i_cmd,
    input  logic                i_wide,
    input  logic                i_signed_mode,
    input  logic [63:0]         i_value,
    input  logic [7:0]          i_in_byte,
    output vzc_pkg::t_dp_status o_status,
    output logic                o_out_kind,
    output logic [7:0]          o_out_byte,
    output logic [63:0]         o_out_value,
    output logic                o_out_last
);

    // encode side
    logic [63:0] r_enc_val, n_enc_val;
    logic [3:0]  r_enc_cnt, n_enc_cnt;
    logic [63:0] enc_mapped;
    logic [63:0] enc_cur;
    logic [3:0]  enc_cur_cnt;
    logic        enc_more;
    logic [7:0]  enc_byte;

    // decode side
    logic [63:0] r_partial, n_partial;
    logic [3:0]  r_bytes, n_bytes;
    logic        r_lwide, n_lwide;
    logic        r_lsigned, n_lsigned;
    logic        dec_first;
    logic        dec_w;
    logic        dec_s;
    logic [6:0]  dec_shift;
    logic [63:0] dec_group;
    logic [63:0] dec_acc;
    logic [3:0]  dec_next;
    logic [3:0]  dec_limit;
    logic        dec_done;
    logic [63:0] dec_raw;
    logic [31:0] dec_nar;
    logic [63:0] dec_result;

    // output register
    logic        r_out_kind;
    logic [7:0]  r_out_byte;
    logic [63:0] r_out_value;
    logic        r_out_last;

    always_comb begin
        if (i_wide) begin
            enc_mapped = i_signed_mode ? ({i_value[62:0], 1'b0} ^ {64{i_value[63]}}) : i_value;
        end else if (i_signed_mode) begin
            enc_mapped = {32'b0, {i_value[30:0], 1'b0} ^ {32{i_value[31]}}};
        end else begin
            enc_mapped = {32'b0, i_value[31:0]};
        end
    end

    assign enc_cur     = i_cmd.load_enc ? enc_mapped : r_enc_val;
    assign enc_cur_cnt = i_cmd.load_enc ? 4'd0 : r_enc_cnt;
    assign enc_more    = (enc_cur[63:7] != 57'b0) && (enc_cur_cnt != 4'(vzc_pkg::ENC_MAX_CNT));
    assign enc_byte    = enc_more ? {1'b1, enc_cur[6:0]} : enc_cur[7:0];

    always_comb begin
        n_enc_val = r_enc_val;
        n_enc_cnt = r_enc_cnt;
        if (i_cmd.load_enc || i_cmd.step_enc) begin
            n_enc_val = {7'b0, enc_cur[63:7]};
            n_enc_cnt = enc_cur_cnt + 4'd1;
        end
    end

    // width and sign come from the first byte of a varint only
    assign dec_first = (r_bytes == 4'd0);
    assign dec_w     = dec_first ? i_wide : r_lwide;
    assign dec_s     = dec_first ? i_signed_mode : r_lsigned;
    assign dec_shift = 7'(r_bytes) * 7'(vzc_pkg::GROUP_BITS);
    assign dec_group = dec_shift[6] ? 64'b0 : ({57'b0, i_in_byte[6:0]} << dec_shift[5:0]);
    assign dec_acc   = r_partial | dec_group;
    assign dec_next  = r_bytes + 4'd1;
    assign dec_limit = dec_w ? 4'(vzc_pkg::WIDE_BYTES) : 4'(vzc_pkg::NARROW_BYTES);
    assign dec_done  = !i_in_byte[7] || (dec_next >= dec_limit);
    assign dec_raw   = dec_w ? dec_acc : {32'b0, dec_acc[31:0]};
    assign dec_nar   = {1'b0, dec_raw[31:1]} ^ {32{dec_raw[0]}};

    always_comb begin
        if (!dec_s) begin
            dec_result = dec_raw;
        end else if (dec_w) begin
            dec_result = {1'b0, dec_raw[63:1]} ^ {64{dec_raw[0]}};
        end else begin
            dec_result = {{32{dec_nar[31]}}, dec_nar};
        end
    end

    always_comb begin
        n_partial = r_partial;
        n_bytes   = r_bytes;
        n_lwide   = r_lwide;
        n_lsigned = r_lsigned;
        if (i_cmd.dec_byte) begin
            n_lwide   = dec_w;
            n_lsigned = dec_s;
            if (dec_done) begin
                n_partial = 64'b0;
                n_bytes   = 4'd0;
            end else begin
                n_partial = dec_acc;
                n_bytes   = dec_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= 64'b0;
            r_bytes   <= 4'd0;
            r_lwide   <= 1'b0;
            r_lsigned <= 1'b0;
        end else begin
            r_partial <= n_partial;
            r_bytes   <= n_bytes;
            r_lwide   <= n_lwide;
            r_lsigned <= n_lsigned;
        end
    end

    always_ff @(posedge i_clk) begin
        r_enc_val <= n_enc_val;
        r_enc_cnt <= n_enc_cnt;
        if (i_cmd.load_enc || i_cmd.step_enc) begin
            r_out_kind  <= vzc_pkg::KIND_ENC;
            r_out_byte  <= enc_byte;
            r_out_value <= 64'b0;
            r_out_last  <= !enc_more;
        end else if (i_cmd.dec_byte && dec_done) begin
            r_out_kind  <= vzc_pkg::KIND_DEC;
            r_out_byte  <= 8'b0;
            r_out_value <= dec_result;
            r_out_last  <= 1'b1;
        end
    end

    assign o_status.enc_more = enc_more;
    assign o_status.dec_done = dec_done;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

[hw/rtl/varint_zigzag_codec_unit.sv]
// Varint codec for 32/64-bit integers, with zigzag mapping in signed mode.
// One input stream (s_axis) carries encode requests or decode bytes,
// selected by tuser bit 0; one output stream (m_axis) carries results.
// Encode: a value beat produces 1..5 (32-bit) or 1..10 (64-bit) byte
// beats, low group first, tlast on the final byte. The first byte appears
// in the cycle after the input beat, then one byte per cycle while the
// receiver takes them; the input is held off (tready low) until the last
// byte is loaded.
// Decode: one byte beat per cycle while tready is high; the byte that
// closes a varint (bit 7 clear, or the 5th / 10th byte) yields one value
// beat with tlast high, in the next cycle. Other decode bytes yield nothing.
// The single output register sets the rate: outside an encode, a new beat
// is taken whenever that register is empty or being drained in the same cycle.
// If the receiver stalls, the output beat holds and the input stalls too.
// Reset (synchronous, i_rst_n low) empties the output register, drops any
// encode in flight and clears the partial decode state.
// Depends on vzc_pkg, vzc_ctrl and vzc_datapath.
module varint_zigzag_codec_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // value[63:0], in_byte[71:64]
    input  logic [2:0]  s_axis_tuser,   // operation[0], wide[1], signed_mode[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_byte[7:0], out_value[71:8]
    output logic        m_axis_tuser,   // kind[0]
    output logic        m_axis_tlast
);

    vzc_pkg::t_dp_cmd    cmd;
    vzc_pkg::t_dp_status status;
    logic [7:0]          out_byte;
    logic [63:0]         out_value;

    vzc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_operation (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vzc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_wide        (s_axis_tuser[1]),
        .i_signed_mode (s_axis_tuser[2]),
        .i_value       (s_axis_tdata[63:0]),
        .i_in_byte     (s_axis_tdata[71:64]),
        .o_status      (status),
        .o_out_kind    (m_axis_tuser),
        .o_out_byte    (out_byte),
        .o_out_value   (out_value),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {out_value, out_byte};

endmodule

[hw/rtl/vzc_checker.sv]
// port-level checks of the codec output stream, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module vzc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled beat keeps its payload
    `VZC_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed under stall")
    // decoded value beats are single and carry no byte
    `VZC_ASSERT(a_dec_shape, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'h00), "decoded beat malformed")
    // encoded byte: continuation bit set exactly on non-final bytes
    `VZC_ASSERT(a_enc_cont, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tlast != m_axis_tdata[7]), "continuation bit disagrees with tlast")
    `VZC_ASSERT_PORT(a_enc_zero_value, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[71:8] == 64'h0))

endmodule

bind varint_zigzag_codec_unit vzc_checker u_vzc_checker (.*);
